[design/ple_pkg.sv]
`default_nettype none
package ple_pkg;

  // list geometry
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int MODE_W   = 3;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // common width for position and count compares, one spare bit for count + 1
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_LOCATE = 3'd3,
    MODE_PRED   = 3'd4,
    MODE_SUCC   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  // shift command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_cmd_t;

  // compare results a cell captures when an item is taken
  typedef struct packed {
    logic live;      // cell holds a list element
    logic gt;        // live and element greater than key
    logic eq;        // live and element equal to key
    logic at_pos;    // cell sits at the requested position
    logic from_pos;  // cell sits at or after the requested position
  } cell_flags_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         result_position;
    logic [POS_W-1:0]         length;
    logic                     empty_res;
  } rsp_t;

endpackage
`default_nettype wire

[design/positional_list_engine_core.sv]
`default_nettype none
// Bounded ordered list of signed 32-bit elements at positions 1 to length.
// Request channel: drive req (mode, position, value) and raise start; the
// item is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall, so each result must be taken in that cycle.
// The item is held in busy and req_q, then the result in rsp and done; no
// new item is taken while busy is high. In the cycle an item is taken,
// every cell of the 64-cell row compares its element against the key and
// position; in the next cycle a priority select over the cell flags picks
// the answer while the row shifts one place for insert or delete. busy is
// high during that cycle only.
// Reset (rst, synchronous) empties the list and clears busy and done;
// element storage is not cleared, only positions 1 to length are read.
module positional_list_engine_core
  import ple_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  logic                     accept;
  req_t                     req_q;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  rsp_t                     rsp_next;
  cell_cmd_t                cmd;
  cell_cmd_t                cell_cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  cell_flags_t              cell_flags [CAPACITY];
  logic [CAPACITY-1:0]      live_v, gt_v, eq_v, at_v;
  logic [CAPACITY-1:0]      mask;
  logic                     found;
  logic [IDX_W-1:0]         sel_idx;
  logic signed [DATA_W-1:0] sel_value;
  logic [CMP_W-1:0]         pos_w;
  logic [CMP_W-1:0]         cnt_w;
  logic                     in_range;
  logic                     ins_ok;

  assign accept = start && !busy;

  // row of cells, each one list slot
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[g+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .capture    (accept),
      .count      (count),
      .position   (req.position),
      .key        (req.value),
      .cmd        (cell_cmd),
      .fill       (req_q.value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .flags      (cell_flags[g])
    );

    assign live_v[g] = cell_flags[g].live;
    assign gt_v[g]   = cell_flags[g].gt;
    assign eq_v[g]   = cell_flags[g].eq;
    assign at_v[g]   = cell_flags[g].at_pos;
  end

  ple_select u_select (
    .mask      (mask),
    .data      (cell_data),
    .found     (found),
    .sel_idx   (sel_idx),
    .sel_value (sel_value)
  );

  // range checks against the held request
  assign pos_w    = CMP_W'(req_q.position);
  assign cnt_w    = CMP_W'(count);
  assign in_range = (pos_w != '0) && (pos_w <= cnt_w);
  assign ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1))
                    && (cnt_w < CMP_W'(CAPACITY));

  // result and row command for the held request
  always_comb begin
    mask       = '0;
    cmd        = CELL_HOLD;
    count_next = count;
    rsp_next   = '0;
    unique case (mode_t'(req_q.mode))
      MODE_INSERT: begin
        if (ins_ok) begin
          cmd          = CELL_INSERT;
          count_next   = count + CNT_W'(1);
          rsp_next.ok  = 1'b1;
        end
      end
      MODE_DELETE: begin
        mask = at_v & live_v;
        if (in_range) begin
          cmd                   = CELL_DELETE;
          count_next            = count - CNT_W'(1);
          rsp_next.ok           = 1'b1;
          rsp_next.result_value = sel_value;
        end
      end
      MODE_READ: begin
        mask = at_v & live_v;
        if (in_range) begin
          rsp_next.ok           = 1'b1;
          rsp_next.result_value = sel_value;
        end
      end
      MODE_LOCATE: begin
        mask = gt_v;
        if (found) begin
          rsp_next.ok              = 1'b1;
          rsp_next.result_position = POS_W'(CNT_W'(sel_idx) + CNT_W'(1));
        end
      end
      MODE_PRED: begin
        // cell just ahead of an equal element; first element has none
        mask = eq_v >> 1;
        if (found && !eq_v[0]) begin
          rsp_next.ok           = 1'b1;
          rsp_next.result_value = sel_value;
        end
      end
      MODE_SUCC: begin
        // live cell just behind an equal element
        mask = (eq_v << 1) & live_v;
        if (found) begin
          rsp_next.ok           = 1'b1;
          rsp_next.result_value = sel_value;
        end
      end
      MODE_CLEAR: begin
        count_next  = '0;
        rsp_next.ok = 1'b1;
      end
      default: begin
      end
    endcase
    rsp_next.length    = POS_W'(count_next);
    rsp_next.empty_res = (count_next == '0);
  end

  assign cell_cmd = busy ? cmd : CELL_HOLD;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy  <= 1'b0;
        count <= count_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

[design/ple_cell.sv]
`default_nettype none
module ple_cell
  import ple_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  logic                     capture,
  input  logic [CNT_W-1:0]         count,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] key,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] fill,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output cell_flags_t              flags
);

  logic [CMP_W-1:0] slot;
  logic [CMP_W-1:0] pos_w;
  cell_flags_t      flags_next;

  // one-based slot number of this cell against the request
  assign slot  = CMP_W'(idx) + CMP_W'(1);
  assign pos_w = CMP_W'(position);

  always_comb begin
    flags_next.live     = CMP_W'(idx) < CMP_W'(count);
    flags_next.gt       = flags_next.live && (data > key);
    flags_next.eq       = flags_next.live && (data == key);
    flags_next.at_pos   = (slot == pos_w);
    flags_next.from_pos = (slot >= pos_w);
  end

  // compare flags are taken along with the item
  always_ff @(posedge clk) begin
    if (capture) begin
      flags <= flags_next;
    end
  end

  // shift toward the tail on insert, toward the head on delete
  always_ff @(posedge clk) begin
    case (cmd)
      CELL_INSERT: begin
        if (flags.at_pos) begin
          data <= fill;
        end else if (flags.from_pos) begin
          data <= left_data;
        end
      end
      CELL_DELETE: begin
        if (flags.from_pos) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[design/ple_select.sv]
`default_nettype none
module ple_select
  import ple_pkg::*;
(
  input  logic [CAPACITY-1:0]      mask,
  input  logic signed [DATA_W-1:0] data [CAPACITY],
  output logic                     found,
  output logic [IDX_W-1:0]         sel_idx,
  output logic signed [DATA_W-1:0] sel_value
);

  logic [CAPACITY-1:0] first;

  // isolate the lowest set bit
  assign first = mask & (~mask + CAPACITY'(1));
  assign found = |mask;

  // and-or gather of index and element of the chosen cell
  always_comb begin
    sel_idx   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        sel_idx   = sel_idx | IDX_W'(i);
        sel_value = sel_value | data[i];
      end
    end
  end

endmodule
`default_nettype wire

[design/ple_checker.sv]
`default_nettype none
module ple_checker
  import ple_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // a taken item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item taken but busy not raised");

  // busy lasts one cycle and is followed by exactly one result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy not followed by a result");

  // no result without work in the cycle before
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  // empty flag agrees with length, length within capacity
  a_len: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.empty_res == (rsp.length == '0))
             && (CNT_W'(rsp.length) <= CNT_W'(CAPACITY)))
    else $error("length and empty flag disagree");

  // a located position always comes with success
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.result_position != '0) |-> rsp.ok)
    else $error("position reported without success");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  import ple_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 360;

  // one row of the directed table
  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  positional_list_engine_core u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int list_len;

  rsp_t     pending_answers [$];
  dir_row_t dir_tab [$];
  rsp_t     mon_want;

  int n_sent;
  int n_checked;
  int n_errors;
  int n_full_refused;
  int peak_len;
  int idle_pct;
  int cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_answers.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
    n_errors++;
  endtask

  // index of the first element equal to key, list_len when absent
  function automatic int first_equal(logic signed [DATA_W-1:0] key);
    int k;
    first_equal = list_len;
    for (k = list_len - 1; k >= 0; k--)
      if (list_mem[k] == key) first_equal = k;
  endfunction

  // apply one request to the shadow list and return its answer
  function automatic rsp_t list_apply(req_t r);
    rsp_t o;
    int p;
    int k;
    int hit;
    o = '0;
    p = int'(r.position);
    case (r.mode)
      MODE_INSERT: begin
        if (list_len == CAPACITY) n_full_refused++;
        if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = r.value;
          list_len++;
          o.ok = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          o.result_value = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
          o.ok = 1'b1;
        end
      end
      MODE_READ: begin
        if (p >= 1 && p <= list_len) begin
          o.result_value = list_mem[p-1];
          o.ok = 1'b1;
        end
      end
      MODE_LOCATE: begin
        for (k = list_len - 1; k >= 0; k--) begin
          if ($signed(list_mem[k]) > $signed(r.value)) begin
            o.result_position = POS_W'(k + 1);
            o.ok = 1'b1;
          end
        end
      end
      MODE_PRED: begin
        hit = first_equal(r.value);
        if (hit < list_len && hit > 0) begin
          o.result_value = list_mem[hit-1];
          o.ok = 1'b1;
        end
      end
      MODE_SUCC: begin
        hit = first_equal(r.value);
        if (hit + 1 < list_len) begin
          o.result_value = list_mem[hit+1];
          o.ok = 1'b1;
        end
      end
      MODE_CLEAR: begin
        list_len = 0;
        o.ok = 1'b1;
      end
      default: begin
      end
    endcase
    if (list_len > peak_len) peak_len = list_len;
    o.length = POS_W'(list_len);
    o.empty_res = (list_len == 0);
    return o;
  endfunction

  // random request, biased toward valid positions and stored keys
  function automatic req_t gen_item();
    req_t r;
    int w;
    int hi;
    r = '0;
    w = $urandom_range(99);
    if (w < 2) r.mode = MODE_CLEAR;
    else if (w < 4) r.mode = MODE_UNUSED;
    else begin
      w = $urandom_range(99);
      if (w < ((list_len < CAPACITY / 2) ? 40 : 20)) r.mode = MODE_INSERT;
      else if (w < 52) r.mode = MODE_DELETE;
      else if (w < 64) r.mode = MODE_READ;
      else if (w < 76) r.mode = MODE_LOCATE;
      else if (w < 88) r.mode = MODE_PRED;
      else r.mode = MODE_SUCC;
    end
    hi = (r.mode == MODE_INSERT) ? list_len + 1 : ((list_len > 0) ? list_len : 1);
    w = $urandom_range(9);
    if (w == 0) r.position = POS_W'($urandom_range(127));
    else if (w == 1) r.position = '0;
    else r.position = POS_W'($urandom_range(hi, 1));
    w = $urandom_range(9);
    if (w < 4 && list_len > 0) r.value = list_mem[$urandom_range(list_len - 1)];
    else if (w < 6) r.value = DATA_W'(int'($urandom_range(16)) - 8);
    else if (w == 6) begin
      case ($urandom_range(3))
        0: r.value = VMIN;
        1: r.value = VMAX;
        2: r.value = '0;
        default: r.value = -1;
      endcase
    end else r.value = $urandom;
    return r;
  endfunction

  function automatic dir_row_t drow(logic [MODE_W-1:0] m, int p,
                                    logic signed [DATA_W-1:0] v);
    dir_row_t d;
    d.rq.mode = m;
    d.rq.position = POS_W'(p);
    d.rq.value = v;
    d.typed = 1'b0;
    d.want = '0;
    return d;
  endfunction

  function automatic dir_row_t trow(logic [MODE_W-1:0] m, int p,
                                    logic signed [DATA_W-1:0] v, int ok,
                                    logic signed [DATA_W-1:0] rv, int rp, int len,
                                    int emp);
    dir_row_t d;
    d = drow(m, p, v);
    d.typed = 1'b1;
    d.want.ok = (ok != 0);
    d.want.result_value = rv;
    d.want.result_position = POS_W'(rp);
    d.want.length = POS_W'(len);
    d.want.empty_res = (emp != 0);
    return d;
  endfunction

  // present one item and hold it until taken
  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t predicted;
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    predicted = list_apply(r);
    pending_answers.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    logic [63:0] noise;
    repeat (n) begin
      @(negedge clk);
      noise = {$urandom, $urandom};
      start <= 1'b0;
      req <= noise[$bits(req_t)-1:0];
    end
  endtask

  task automatic maybe_idle();
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) idle_cycles($urandom_range(4, 1));
  endtask

  // hold off until every outstanding answer is back
  task automatic drain();
    idle_cycles(1);
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // fill the list to capacity, then push against the full list
  task automatic fill_up();
    req_t r;
    while (list_len < CAPACITY) begin
      r.mode = MODE_INSERT;
      r.position = POS_W'($urandom_range(list_len + 1, 1));
      r.value = $urandom;
      maybe_idle();
      send_item(r, 1'b0, '0);
    end
    repeat (2) begin
      r.mode = MODE_INSERT;
      r.position = POS_W'($urandom_range(CAPACITY + 1, 1));
      r.value = $urandom;
      send_item(r, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report("result with nothing pending", rsp.result_value, '0);
      end else begin
        mon_want = pending_answers.pop_front();
        if (rsp.ok !== mon_want.ok)
          report("ok", DATA_W'(rsp.ok), DATA_W'(mon_want.ok));
        if (rsp.result_value !== mon_want.result_value)
          report("result_value", rsp.result_value, mon_want.result_value);
        if (rsp.result_position !== mon_want.result_position)
          report("result_position", DATA_W'(rsp.result_position),
                 DATA_W'(mon_want.result_position));
        if (rsp.length !== mon_want.length)
          report("length", DATA_W'(rsp.length), DATA_W'(mon_want.length));
        if (rsp.empty_res !== mon_want.empty_res)
          report("empty_res", DATA_W'(rsp.empty_res), DATA_W'(mon_want.empty_res));
        n_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int i;
    int phase;
    int pcts [4];
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    list_len = 0;
    idle_pct = 0;
    pcts = '{0, 77, 0, 31};

    // directed table: empty list errors, extremes, every mode and its failures
    dir_tab.push_back(trow(MODE_READ,    1, 0,    0, 0,    0, 0, 1));
    dir_tab.push_back(trow(MODE_DELETE,  0, 0,    0, 0,    0, 0, 1));
    dir_tab.push_back(trow(MODE_INSERT,  0, 5,    0, 0,    0, 0, 1));
    dir_tab.push_back(trow(MODE_INSERT,  2, 5,    0, 0,    0, 0, 1));
    dir_tab.push_back(trow(MODE_INSERT,  1, VMAX, 1, 0,    0, 1, 0));
    dir_tab.push_back(trow(MODE_INSERT,  2, VMIN, 1, 0,    0, 2, 0));
    dir_tab.push_back(trow(MODE_INSERT,  1, 0,    1, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_READ,    0, 0,    0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_READ,  127, 0,    0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_READ,    3, 0,    1, VMIN, 0, 3, 0));
    dir_tab.push_back(trow(MODE_LOCATE,  0, VMAX, 0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_LOCATE,  0, VMIN, 1, 0,    1, 3, 0));
    dir_tab.push_back(drow(MODE_LOCATE,  0, 0));
    dir_tab.push_back(trow(MODE_PRED,    0, 0,    0, 0,    0, 3, 0));
    dir_tab.push_back(drow(MODE_PRED,    0, VMIN));
    dir_tab.push_back(trow(MODE_SUCC,    0, VMIN, 0, 0,    0, 3, 0));
    dir_tab.push_back(drow(MODE_SUCC,    0, 0));
    dir_tab.push_back(trow(MODE_PRED,    0, 5,    0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_SUCC,    0, 5,    0, 0,    0, 3, 0));
    dir_tab.push_back(drow(MODE_INSERT,  4, -1));
    dir_tab.push_back(drow(MODE_INSERT,  2, 0));
    dir_tab.push_back(drow(MODE_SUCC,    0, 0));
    dir_tab.push_back(drow(MODE_DELETE,  5, 0));
    dir_tab.push_back(drow(MODE_DELETE,  1, 0));
    dir_tab.push_back(trow(MODE_DELETE,  4, 0,    0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_UNUSED,  1, 0,    0, 0,    0, 3, 0));
    dir_tab.push_back(trow(MODE_CLEAR,   0, 0,    1, 0,    0, 0, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < dir_tab.size(); i++) send_item(dir_tab[i].rq, dir_tab[i].typed,
                                                   dir_tab[i].want);
    drain();

    // random phases, two without sender idle gaps and two with
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = pcts[phase];
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) fill_up();
        maybe_idle();
        send_item(gen_item(), 1'b0, '0);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("sent %0d requests in four pacing phases, compared %0d answers",
             n_sent, n_checked);
    $display("list grew to %0d entries, %0d inserts hit a full list", peak_len,
             n_full_refused);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
